@@ rtl/ilir_pkg.sv @@
package ilir_pkg;

  // Store depth of the list.
  localparam int DEPTH = 16;

  // Width of a live count (0..DEPTH), of a store index, and of the field
  // comparison width that holds a position, a count and a capacity.
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

  // Fixed field widths.
  localparam int KIND_W = 3;
  localparam int POS_W = 5;
  localparam int VAL_W = 32;
  localparam int STATUS_W = 2;
  localparam int FOUND_W = 5;
  localparam int CAP_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Operation codes.
  localparam logic [KIND_W-1:0] K_INSERT = 3'd0;
  localparam logic [KIND_W-1:0] K_REMOVE = 3'd1;
  localparam logic [KIND_W-1:0] K_REVERSE = 3'd2;
  localparam logic [KIND_W-1:0] K_FIND = 3'd3;
  localparam logic [KIND_W-1:0] K_READ = 3'd4;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  localparam logic signed [FOUND_W-1:0] FOUND_NONE = -5'sd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;     // capture the accepted request
    logic exec;      // commit the operation and load the result registers
    logic rev_init;  // set up the reverse pointers
    logic rev_load;  // hold the low entry of the current pair
    logic rev_swap;  // write the pair back crossed and step the pointers
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic rev_needed;  // request is a reverse with at least one pair to swap
    logic more_pairs;  // another pair remains after the current swap
  } dp_sts_t;

endpackage

@@ rtl/ilir_dp.sv @@
module ilir_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  ilir_pkg::dp_cmd_t                      cmd,
  output ilir_pkg::dp_sts_t                      sts,
  input  logic [ilir_pkg::KIND_W-1:0]            in_kind,
  input  logic [ilir_pkg::POS_W-1:0]             in_position,
  input  logic signed [ilir_pkg::VAL_W-1:0]      in_item_value,
  input  logic                                   cfg_we,
  input  logic [ilir_pkg::CAP_W-1:0]             cfg_wdata,
  output logic [ilir_pkg::STATUS_W-1:0]          out_status,
  output logic signed [ilir_pkg::FOUND_W-1:0]    out_found_at,
  output logic signed [ilir_pkg::VAL_W-1:0]      out_read_data,
  output logic [ilir_pkg::POS_W-1:0]             out_entry_count
);
  import ilir_pkg::*;

  logic signed [VAL_W-1:0]    ent_r [DEPTH];
  logic [CNT_W-1:0]           count_r;
  logic [CAP_W-1:0]           cap_r;
  logic [KIND_W-1:0]          kind_r;
  logic [POS_W-1:0]           pos_r;
  logic signed [VAL_W-1:0]    val_r;
  logic [IDX_W-1:0]           lo_r;
  logic [IDX_W-1:0]           hi_r;
  logic signed [VAL_W-1:0]    tmp_r;
  logic [STATUS_W-1:0]        status_r;
  logic signed [FOUND_W-1:0]  found_r;
  logic signed [VAL_W-1:0]    rdata_r;
  logic [POS_W-1:0]           ocount_r;

  logic [CMP_W-1:0]           pos_x;
  logic [CMP_W-1:0]           cnt_x;
  logic [CMP_W-1:0]           cap_x;
  logic [CMP_W-1:0]           cap_eff;
  logic                       ins_ok;
  logic                       rem_ok;
  logic [IDX_W-1:0]           rd_idx;
  logic signed [VAL_W-1:0]    rd_data;
  logic signed [FOUND_W-1:0]  find_idx;
  logic [STATUS_W-1:0]        status_nxt;
  logic signed [FOUND_W-1:0]  found_nxt;
  logic signed [VAL_W-1:0]    rdata_nxt;
  logic [CNT_W-1:0]           count_nxt;

  assign pos_x = CMP_W'(pos_r);
  assign cnt_x = CMP_W'(count_r);
  assign cap_x = CMP_W'(cap_r);
  assign cap_eff = (cap_x < CMP_W'(DEPTH)) ? cap_x : CMP_W'(DEPTH);

  // Insert may target one past the last entry; it must also find room.
  assign ins_ok = (pos_x <= cnt_x) && (cnt_x < cap_eff);
  assign rem_ok = pos_x < cnt_x;

  // The one shared read port of the store.
  always_comb begin
    if (cmd.rev_load) begin
      rd_idx = lo_r;
    end else if (cmd.rev_swap) begin
      rd_idx = hi_r;
    end else begin
      rd_idx = IDX_W'(pos_r);
    end
  end
  assign rd_data = ent_r[rd_idx];

  // First live match wins, so scan from the top down.
  always_comb begin
    find_idx = FOUND_NONE;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if ((CMP_W'(i) < cnt_x) && (ent_r[i] == val_r)) begin
        find_idx = FOUND_W'(i);
      end
    end
  end

  always_comb begin
    status_nxt = ST_OK;
    found_nxt = '0;
    rdata_nxt = '0;
    count_nxt = count_r;
    unique case (kind_r)
      K_INSERT: begin
        if (pos_x > cnt_x) begin
          status_nxt = ST_RANGE;
        end else if (!ins_ok) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      K_REMOVE: begin
        if (!rem_ok) begin
          status_nxt = ST_RANGE;
        end else begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      K_FIND: begin
        found_nxt = find_idx;
      end
      K_READ: begin
        if (!rem_ok) begin
          status_nxt = ST_RANGE;
        end else begin
          rdata_nxt = rd_data;
        end
      end
      default: begin
      end
    endcase
  end

  assign sts.rev_needed = (kind_r == K_REVERSE) && (count_r >= CNT_W'(2));
  assign sts.more_pairs = ({1'b0, lo_r} + (IDX_W + 1)'(2)) < {1'b0, hi_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      cap_r <= CAP_RESET;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (cmd.exec) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_r <= in_kind;
      pos_r <= in_position;
      val_r <= in_item_value;
    end
    if (cmd.rev_init) begin
      lo_r <= '0;
      hi_r <= IDX_W'(count_r - CNT_W'(1));
    end else if (cmd.rev_swap) begin
      lo_r <= lo_r + IDX_W'(1);
      hi_r <= hi_r - IDX_W'(1);
    end
    if (cmd.rev_load) begin
      tmp_r <= rd_data;
    end
    if (cmd.exec) begin
      status_r <= status_nxt;
      found_r <= found_nxt;
      rdata_r <= rdata_nxt;
      ocount_r <= POS_W'(count_nxt);
    end
  end

  // List store: every cell takes its own value, a neighbor, the new value,
  // or the other half of a reverse pair.
  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (cmd.exec && (kind_r == K_INSERT) && ins_ok) begin
        if (CMP_W'(i) == pos_x) begin
          ent_r[i] <= val_r;
        end else if ((i > 0) && (CMP_W'(i) > pos_x) && (CMP_W'(i) <= cnt_x)) begin
          ent_r[i] <= ent_r[(i > 0) ? i - 1 : 0];
        end
      end else if (cmd.exec && (kind_r == K_REMOVE) && rem_ok) begin
        if ((i < DEPTH - 1) && (CMP_W'(i) >= pos_x) && (CMP_W'(i + 1) < cnt_x)) begin
          ent_r[i] <= ent_r[(i < DEPTH - 1) ? i + 1 : i];
        end
      end else if (cmd.rev_swap) begin
        if (IDX_W'(i) == lo_r) begin
          ent_r[i] <= rd_data;
        end else if (IDX_W'(i) == hi_r) begin
          ent_r[i] <= tmp_r;
        end
      end
    end
  end

  assign out_status = status_r;
  assign out_found_at = found_r;
  assign out_read_data = rdata_r;
  assign out_entry_count = ocount_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(count_r) <= CMP_W'(DEPTH))
    else $error("live count exceeds the store depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && (kind_r == K_INSERT) && ins_ok) |=>
      (count_r == $past(count_r) + CNT_W'(1)))
    else $error("successful insert did not grow the list by one");

  a_swap_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rev_swap |-> (lo_r < hi_r))
    else $error("reverse pointers crossed before a swap");

endmodule

@@ rtl/ilir_ctrl.sv @@
module ilir_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output ilir_pkg::dp_cmd_t  cmd,
  input  ilir_pkg::dp_sts_t  sts
);
  import ilir_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_REV_A = 3'd2;
  localparam logic [2:0] S_REV_B = 3'd3;
  localparam logic [2:0] S_FIN = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       slot_free;

  // The result register may be reloaded when it is empty or being taken.
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.rev_needed) begin
          cmd.rev_init = 1'b1;
          state_nxt = S_REV_A;
        end else if (slot_free) begin
          cmd.exec = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_REV_A: begin
        cmd.rev_load = 1'b1;
        state_nxt = S_REV_B;
      end
      S_REV_B: begin
        cmd.rev_swap = 1'b1;
        state_nxt = sts.more_pairs ? S_REV_A : S_FIN;
      end
      S_FIN: begin
        if (slot_free) begin
          cmd.exec = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_exec_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> slot_free)
    else $error("result loaded while the previous one was still held");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.latch, cmd.exec, cmd.rev_init, cmd.rev_load, cmd.rev_swap}))
    else $error("more than one datapath command in a cycle");

  a_swap_follows_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rev_load |=> cmd.rev_swap)
    else $error("reverse load not followed by its swap");

endmodule

@@ rtl/indexed_list_insert_remove.sv @@
// Ordered list of signed 32-bit values held in a store of DEPTH entries.
// Each request on the in_ channel carries one operation (insert, remove,
// reverse, find or read) selected by in_kind; each request gives exactly one
// result on the out_ channel with a status, a find index, read data and the
// live count after the operation. Both channels use valid/ready.
// cfg_we writes the capacity register from cfg_wdata; write it only while
// the block is idle. An effective capacity above DEPTH is clamped to DEPTH.
// A request is latched into the request registers, then committed into the
// result registers once the output slot is free. A reverse of two or more
// entries first sets up its pointers, then swaps its pairs one at a time
// through the single shared read port of the store (load the low entry,
// then write the pair back crossed) and commits last. One request at a
// time; the next request is taken in the cycle after the previous one loads
// its result. Insert and remove shift the whole store as they commit.
// Reset (rst_n low at a clock edge) empties the list and sets the capacity
// to 16. The store contents are not cleared.
// When the receiver stalls, the result stays in the output register; the
// next request may be accepted and waits before committing until the held
// result is taken.
module indexed_list_insert_remove (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [ilir_pkg::KIND_W-1:0]          in_kind,
  input  logic [ilir_pkg::POS_W-1:0]           in_position,
  input  logic signed [ilir_pkg::VAL_W-1:0]    in_item_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [ilir_pkg::STATUS_W-1:0]        out_status,
  output logic signed [ilir_pkg::FOUND_W-1:0]  out_found_at,
  output logic signed [ilir_pkg::VAL_W-1:0]    out_read_data,
  output logic [ilir_pkg::POS_W-1:0]           out_entry_count,
  input  logic                                 cfg_we,
  input  logic [ilir_pkg::CAP_W-1:0]           cfg_wdata
);
  import ilir_pkg::*;

  // The controller sequences each request; the datapath holds the list,
  // the capacity register and the result registers.
  dp_cmd_t cmd;
  dp_sts_t sts;

  ilir_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  ilir_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_kind         (in_kind),
    .in_position     (in_position),
    .in_item_value   (in_item_value),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_status      (out_status),
    .out_found_at    (out_found_at),
    .out_read_data   (out_read_data),
    .out_entry_count (out_entry_count)
  );

endmodule
